@@ hw/rtl/mlpq_pkg.sv @@
// Package for the multilevel priority queue core.
// Holds sizes, command and status codes, and the structs that the control
// module passes to the store and to the top. No dependencies.
package mlpq_pkg;

	// Block sizes
	localparam int LEVELS     = 8;
	localparam int DEPTH      = 8;
	localparam int DATA_WIDTH = 32;

	// Field widths of the command and result words
	localparam int LEVEL_FW = 3;
	localparam int VALUE_FW = 32;
	localparam int STATUS_FW = 2;

	// Derived widths
	localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = $clog2(LEVELS * DEPTH);

	// Command codes
	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_DELETE = 1'b1
	} cmd_t;

	// Result status codes
	typedef enum logic [STATUS_FW-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	// Entry store access for one command
	typedef struct packed {
		logic                  wr_en;
		logic                  rd_en;
		logic [ADDR_W-1:0]     addr;
		logic [DATA_WIDTH-1:0] wdata;
	} mem_req_t;

	// Outcome of one command, before the store read data is joined in
	typedef struct packed {
		logic             valid;
		logic             pop;
		status_t          status;
		logic [LVL_W-1:0] level;
	} result_t;

endpackage

@@ hw/rtl/mlpq_store.sv @@
// Entry store of the multilevel priority queue: one memory, one port.
// Depends on mlpq_pkg for sizes and the request struct.
module mlpq_store (
	input  logic                           clk,
	input  mlpq_pkg::mem_req_t             req,
	output logic [mlpq_pkg::DATA_WIDTH-1:0] rd_data
);

	logic [mlpq_pkg::DATA_WIDTH-1:0] mem_q [mlpq_pkg::LEVELS * mlpq_pkg::DEPTH];
	logic [mlpq_pkg::DATA_WIDTH-1:0] rd_data_q;

	// Write one entry, or read one entry into the output register
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/mlpq_ctrl.sv @@
// Control of the multilevel priority queue: per-level head, tail and fill
// count, the priority pick on delete, and the store request.
// Depends on mlpq_pkg.
module mlpq_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid,
	input  mlpq_pkg::cmd_t                      command,
	input  logic [mlpq_pkg::LEVEL_FW-1:0]       level,
	input  logic [mlpq_pkg::VALUE_FW-1:0]       item_value,
	output mlpq_pkg::mem_req_t                  req,
	output mlpq_pkg::result_t                   res
);

	localparam logic [mlpq_pkg::PTR_W-1:0] LAST_SLOT = mlpq_pkg::PTR_W'(mlpq_pkg::DEPTH - 1);
	localparam logic [mlpq_pkg::CNT_W-1:0] FULL_CNT  = mlpq_pkg::CNT_W'(mlpq_pkg::DEPTH);

	logic [mlpq_pkg::PTR_W-1:0] head_q [mlpq_pkg::LEVELS];
	logic [mlpq_pkg::PTR_W-1:0] tail_q [mlpq_pkg::LEVELS];
	logic [mlpq_pkg::CNT_W-1:0] occ_q  [mlpq_pkg::LEVELS];

	logic [mlpq_pkg::LEVELS-1:0] nonempty;
	logic                        any_full;
	logic [mlpq_pkg::LVL_W-1:0]  pick_lvl;
	logic [mlpq_pkg::LVL_W-1:0]  ins_lvl;
	logic                        ins_in_range;
	logic                        do_push;
	logic                        do_pop;
	logic [mlpq_pkg::LVL_W-1:0]  act_lvl;
	logic [mlpq_pkg::PTR_W-1:0]  act_slot;

	// Find the most urgent non-empty level
	always_comb begin
		pick_lvl = '0;
		for (int i = mlpq_pkg::LEVELS - 1; i >= 0; i--) begin
			nonempty[i] = (occ_q[i] != '0);
			if (nonempty[i]) begin
				pick_lvl = mlpq_pkg::LVL_W'(i);
			end
		end
	end

	// Decide the action for the word in flight
	always_comb begin
		ins_in_range = (32'(level) < 32'(mlpq_pkg::LEVELS));
		ins_lvl      = mlpq_pkg::LVL_W'(level);
		any_full     = (occ_q[ins_lvl] >= FULL_CNT);
		do_push      = valid && (command == mlpq_pkg::CMD_INSERT) && ins_in_range && !any_full;
		do_pop       = valid && (command == mlpq_pkg::CMD_DELETE) && (|nonempty);
		act_lvl      = do_pop ? pick_lvl : ins_lvl;
		act_slot     = do_pop ? head_q[pick_lvl] : tail_q[ins_lvl];

		req.wr_en = do_push;
		req.rd_en = do_pop;
		req.addr  = mlpq_pkg::ADDR_W'(act_lvl) * mlpq_pkg::ADDR_W'(mlpq_pkg::DEPTH)
			+ mlpq_pkg::ADDR_W'(act_slot);
		req.wdata = mlpq_pkg::DATA_WIDTH'($signed(item_value));

		res.valid = valid;
		res.pop   = do_pop;
		res.level = do_pop ? pick_lvl : '0;
		if (command == mlpq_pkg::CMD_INSERT) begin
			res.status = (ins_in_range && !any_full) ? mlpq_pkg::ST_OK : mlpq_pkg::ST_OVERFLOW;
		end else begin
			res.status = (|nonempty) ? mlpq_pkg::ST_OK : mlpq_pkg::ST_UNDERFLOW;
		end
	end

	// Advance tail on push, head on pop, and track the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mlpq_pkg::LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				occ_q[i]  <= '0;
			end
		end else begin
			if (do_push) begin
				tail_q[ins_lvl] <= (act_slot == LAST_SLOT) ? '0 : act_slot + 1'b1;
				occ_q[ins_lvl]  <= occ_q[ins_lvl] + 1'b1;
			end
			if (do_pop) begin
				head_q[pick_lvl] <= (act_slot == LAST_SLOT) ? '0 : act_slot + 1'b1;
				occ_q[pick_lvl]  <= occ_q[pick_lvl] - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/multilevel_priority_queue_core.sv @@
// Multilevel priority queue: one circular FIFO per priority level.
// Commands enter on start; every command returns one result word on done.
// Command channel: command (0 insert, 1 delete), level, item_value. A word
//   is taken at each rising edge with start high and busy low; busy stays
//   low, so a word can be taken in every cycle.
// Result channel: status, out_value, out_level, valid for the single cycle
//   in which done is high. The receiver cannot stall, so each result is
//   shown exactly once.
// Pipeline: a taken word passes two register stages: the command register,
//   then the result register and the registered store read port.
// Throughput: one command per cycle; the fill counts are updated in the
//   same cycle that the level is picked, so back-to-back commands see each
//   other at once.
// Reset: arst_n clears all heads, tails and fill counts, and empties the
//   pipeline. The entry store is not cleared; only filled slots are read.
// Status: 0 ok, 1 overflow (level full or out of range), 2 underflow (all
//   levels empty). On anything but a good delete, out_value and out_level
//   are zero.
// Depends on mlpq_pkg, mlpq_ctrl and mlpq_store.
module multilevel_priority_queue_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 command,
	input  logic [mlpq_pkg::LEVEL_FW-1:0]        level,
	input  logic signed [mlpq_pkg::VALUE_FW-1:0] item_value,
	output logic                                 done,
	output logic [mlpq_pkg::STATUS_FW-1:0]       status,
	output logic signed [mlpq_pkg::VALUE_FW-1:0] out_value,
	output logic [mlpq_pkg::LEVEL_FW-1:0]        out_level
);

	logic                            valid_s1;
	mlpq_pkg::cmd_t                  cmd_s1;
	logic [mlpq_pkg::LEVEL_FW-1:0]   level_s1;
	logic [mlpq_pkg::VALUE_FW-1:0]   value_s1;
	mlpq_pkg::mem_req_t              req;
	mlpq_pkg::result_t               res;
	mlpq_pkg::result_t               res_s2;
	logic [mlpq_pkg::DATA_WIDTH-1:0] rd_data;

	assign busy = 1'b0;

	// Register the command word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1   <= mlpq_pkg::cmd_t'(command);
			level_s1 <= level;
			value_s1 <= item_value;
		end
	end

	mlpq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (valid_s1),
		.command    (cmd_s1),
		.level      (level_s1),
		.item_value (value_s1),
		.req        (req),
		.res        (res)
	);

	mlpq_store u_store (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

	// Hold the outcome alongside the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else begin
			res_s2 <= res;
		end
	end

	// Drive the result word
	assign done      = res_s2.valid;
	assign status    = res_s2.status;
	assign out_level = mlpq_pkg::LEVEL_FW'(res_s2.level);
	assign out_value = res_s2.pop ? mlpq_pkg::VALUE_FW'($signed(rd_data)) : '0;

endmodule

@@ hw/rtl/mlpq_checker.sv @@
// Port checker for the multilevel priority queue core, attached by bind.
// Depends on mlpq_pkg for the command and status codes.
module mlpq_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic                                 command,
	input logic                                 done,
	input logic [mlpq_pkg::STATUS_FW-1:0]       status,
	input logic signed [mlpq_pkg::VALUE_FW-1:0] out_value,
	input logic [mlpq_pkg::LEVEL_FW-1:0]        out_level
);

	// Every accepted word returns its result on done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result missing two cycles after accept");

	// No result without an accepted word
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without an accepted word");

	// Inserts never underflow, deletes never overflow
	a_status_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2
		((($past(command, 2) == mlpq_pkg::CMD_INSERT) && (status != mlpq_pkg::ST_UNDERFLOW))
		|| (($past(command, 2) == mlpq_pkg::CMD_DELETE) && (status != mlpq_pkg::ST_OVERFLOW))))
		else $error("status does not fit the command");

	// Failed results carry zero value and level
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != mlpq_pkg::ST_OK))
		|-> ((out_value == '0) && (out_level == '0)))
		else $error("nonzero fields on a failed command");

endmodule

bind multilevel_priority_queue_core mlpq_checker u_mlpq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.command   (command),
	.done      (done),
	.status    (status),
	.out_value (out_value),
	.out_level (out_level)
);

@@ dv/tb_multilevel_priority_queue_core.sv @@
// Testbench for multilevel_priority_queue_core: directed and random insert/delete
// traffic, checked against a per-level FIFO predictor kept in the bench.
// Depends on mlpq_pkg and the core RTL.
module tb_multilevel_priority_queue_core;

	typedef struct {
		mlpq_pkg::status_t                     st;
		logic signed [mlpq_pkg::VALUE_FW-1:0]  val;
		logic [mlpq_pkg::LEVEL_FW-1:0]         lvl;
	} queue_result_t;

	logic                                  clk;
	logic                                  arst_n;
	logic                                  start;
	logic                                  busy;
	logic                                  command;
	logic [mlpq_pkg::LEVEL_FW-1:0]         level;
	logic signed [mlpq_pkg::VALUE_FW-1:0]  item_value;
	logic                                  done;
	logic [mlpq_pkg::STATUS_FW-1:0]        status;
	logic signed [mlpq_pkg::VALUE_FW-1:0]  out_value;
	logic [mlpq_pkg::LEVEL_FW-1:0]         out_level;

	// Predictor state: one circular FIFO per level
	logic [mlpq_pkg::DATA_WIDTH-1:0] lvl_slots [mlpq_pkg::LEVELS][mlpq_pkg::DEPTH];
	int unsigned                     lvl_head [mlpq_pkg::LEVELS];
	int unsigned                     lvl_tail [mlpq_pkg::LEVELS];
	int unsigned                     lvl_fill [mlpq_pkg::LEVELS];

	queue_result_t pending_results[$];
	int            fail_count = 0;
	bit            no_gap_run = 0;

	multilevel_priority_queue_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.level      (level),
		.item_value (item_value),
		.done       (done),
		.status     (status),
		.out_value  (out_value),
		.out_level  (out_level)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Work out the result of one accepted word and advance the FIFO state
	function automatic queue_result_t predict_queue_op(mlpq_pkg::cmd_t cmd,
			logic [mlpq_pkg::LEVEL_FW-1:0] lvl,
			logic signed [mlpq_pkg::VALUE_FW-1:0] val);
		queue_result_t                        res;
		int                                   i;
		int                                   pick;
		logic signed [mlpq_pkg::VALUE_FW-1:0] widened;
		res.st  = mlpq_pkg::ST_OK;
		res.val = '0;
		res.lvl = '0;
		pick    = -1;
		if (cmd == mlpq_pkg::CMD_INSERT) begin
			if (int'(lvl) >= mlpq_pkg::LEVELS || lvl_fill[lvl] >= mlpq_pkg::DEPTH) begin
				res.st = mlpq_pkg::ST_OVERFLOW;
			end else begin
				lvl_slots[lvl][lvl_tail[lvl]] = val;
				lvl_tail[lvl] = (lvl_tail[lvl] + 1) % mlpq_pkg::DEPTH;
				lvl_fill[lvl]++;
			end
		end else begin
			for (i = mlpq_pkg::LEVELS - 1; i >= 0; i--) begin
				if (lvl_fill[i] != 0)
					pick = i;
			end
			if (pick < 0) begin
				res.st = mlpq_pkg::ST_UNDERFLOW;
			end else begin
				// stored width and port width are both 32 bits, so the value passes as it is
				widened = $signed(lvl_slots[pick][lvl_head[pick]]);
				res.val = widened;
				res.lvl = pick[mlpq_pkg::LEVEL_FW-1:0];
				lvl_head[pick] = (lvl_head[pick] + 1) % mlpq_pkg::DEPTH;
				lvl_fill[pick]--;
			end
		end
		return res;
	endfunction

	// Drive one word, hold it until taken, and queue its expected result
	task automatic send_word(mlpq_pkg::cmd_t cmd, logic [mlpq_pkg::LEVEL_FW-1:0] lvl,
			logic signed [mlpq_pkg::VALUE_FW-1:0] val);
		int gap;
		gap = no_gap_run ? 0 : $urandom_range(0, 9);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start      <= 1'b1;
		command    <= cmd;
		level      <= lvl;
		item_value <= val;
		do @(posedge clk); while (busy);
		pending_results.push_back(predict_queue_op(cmd, lvl, val));
	endtask

	// Hold off the sender until every expected word has come back
	task automatic wait_results_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [mlpq_pkg::VALUE_FW-1:0] pick_value();
		case ($urandom_range(0, 15))
			0:       return 32'sh7fff_ffff;
			1:       return 32'sh8000_0000;
			2:       return '0;
			3:       return -1;
			default: return $urandom;
		endcase
	endfunction

	// Compare each result word with the oldest expectation
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: status %0d value %0d level %0d",
					status, out_value, out_level);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					fail_count++;
				end
				if (out_value !== want.val) begin
					$error("out_value: expected %0d, got %0d", want.val, out_value);
					fail_count++;
				end
				if (out_level !== want.lvl) begin
					$error("out_level: expected %0d, got %0d", want.lvl, out_level);
					fail_count++;
				end
			end
		end
	end

	// Delete with every level empty
	task automatic test_empty_delete();
		send_word(mlpq_pkg::CMD_DELETE, 3'd5, 32'sh1234_5678);
	endtask

	// Fill the least urgent level with extreme values, then overflow it
	task automatic test_full_level();
		logic signed [mlpq_pkg::VALUE_FW-1:0] fill_vals [mlpq_pkg::DEPTH];
		int i;
		fill_vals = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, -32'sd1, 32'sd5,
			32'sh5555_5555, 32'shaaaa_aaaa, 32'sd1};
		for (i = 0; i < mlpq_pkg::DEPTH; i++)
			send_word(mlpq_pkg::CMD_INSERT, 3'd7, fill_vals[i]);
		send_word(mlpq_pkg::CMD_INSERT, 3'd7, 32'sd99);
	endtask

	// Urgent levels leave first; drain all, then underflow once more
	task automatic test_priority_order();
		int i;
		send_word(mlpq_pkg::CMD_INSERT, 3'd0, -32'sd1);
		send_word(mlpq_pkg::CMD_INSERT, 3'd3, 32'sd5);
		send_word(mlpq_pkg::CMD_DELETE, 3'd7, 32'sh0);
		send_word(mlpq_pkg::CMD_DELETE, 3'd0, -32'sd1);
		for (i = 0; i < mlpq_pkg::DEPTH; i++)
			send_word(mlpq_pkg::CMD_DELETE, mlpq_pkg::LEVEL_FW'($urandom_range(0, 7)),
				$urandom);
		send_word(mlpq_pkg::CMD_DELETE, 3'd0, 32'sh0);
	endtask

	// One random phase: insert bias and a band of levels
	task automatic test_random_traffic(int n_words, int insert_pct, int lo_lvl, int hi_lvl);
		int             i;
		mlpq_pkg::cmd_t cmd;
		for (i = 0; i < n_words; i++) begin
			if ($urandom_range(0, 15) == 0)
				no_gap_run = !no_gap_run;
			cmd = ($urandom_range(0, 99) < insert_pct) ? mlpq_pkg::CMD_INSERT
				: mlpq_pkg::CMD_DELETE;
			if (cmd == mlpq_pkg::CMD_INSERT)
				send_word(cmd, mlpq_pkg::LEVEL_FW'($urandom_range(lo_lvl, hi_lvl)),
					pick_value());
			else
				send_word(cmd, mlpq_pkg::LEVEL_FW'($urandom_range(0, 7)), $urandom);
		end
		no_gap_run = 0;
	endtask

	initial begin
		int i;
		for (i = 0; i < mlpq_pkg::LEVELS; i++) begin
			lvl_head[i] = 0;
			lvl_tail[i] = 0;
			lvl_fill[i] = 0;
		end
		arst_n     = 1'b0;
		start      = 1'b0;
		command    = mlpq_pkg::CMD_INSERT;
		level      = '0;
		item_value = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_delete();
		test_full_level();
		test_priority_order();
		wait_results_drained();

		// fill the urgent levels past full, then drain with wrapped pointers
		test_random_traffic(500, 70, 0, 1);
		wait_results_drained();
		test_random_traffic(400, 30, 0, 7);
		test_random_traffic(450, 55, 4, 7);
		wait_results_drained();
		test_random_traffic(450, 25, 0, 7);

		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb_multilevel_priority_queue_core: clean");
		else
			$display("tb_multilevel_priority_queue_core: errors");
		$finish;
	end

	// Guard against a hang
	initial begin
		#5000000;
		$display("tb_multilevel_priority_queue_core: errors");
		$finish;
	end

endmodule

@@ multilevel_priority_queue_core.f @@
hw/rtl/mlpq_pkg.sv
hw/rtl/mlpq_store.sv
hw/rtl/mlpq_ctrl.sv
hw/rtl/multilevel_priority_queue_core.sv
hw/rtl/mlpq_checker.sv
dv/tb_multilevel_priority_queue_core.sv
